// ===== sv/ep2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// ep2cal_pkg
// Shared constants, reciprocal multipliers and the month table for the
// epoch-seconds to calendar-date converter.
// ----------------------------------------------------------------------------
package ep2cal_pkg;

  // Field widths
  localparam int unsigned EpochW  = 31;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 11;

  // Internal widths
  localparam int unsigned DaysW   = 15;  // whole days since 1970, < 24856
  localparam int unsigned Days1900W = 16;  // whole days since 1900, < 50424
  localparam int unsigned SodW    = 17;  // second of day, < 86400
  localparam int unsigned CycW    = 6;   // four-year cycles since 1900, < 35
  localparam int unsigned DoyCycW = 11;  // day within a four-year period, < 1461
  localparam int unsigned SohW    = 12;  // second of hour, < 3600
  localparam int unsigned DoyW    = 9;   // day of year, <= 365
  localparam int unsigned YqW     = 2;   // extra years within a four-year period, <= 3

  // Register ranks from input to output
  localparam int unsigned NumStages = 7;

  // Calendar constants
  localparam int unsigned SecsPerDay    = 86400;
  localparam int unsigned SecsPerHour   = 3600;
  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned Days1900To1970 = 70 * 365 + 18;
  localparam int unsigned DaysPerCycle  = 365 * 4 + 1;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned LeapYearDays  = 366;
  localparam int unsigned BaseYear      = 1900;
  localparam int unsigned FebEndCommon  = 31 + 28;
  localparam int unsigned NumMonths     = 12;

  // Reciprocal divide: q = (x * RECIP) >> SHIFT, exact for the operand range.
  // Day split: t / 86400 = (t >> 7) / 675, operand below 2^24.
  localparam int unsigned DayPreShift = 7;
  localparam int unsigned DayShift    = 34;
  localparam logic [63:0] DayRecipW   = ((64'd1 << DayShift) + 64'd674) / 64'd675;
  localparam int unsigned DayRecipBits = 25;
  localparam logic [DayRecipBits-1:0] DayRecip = DayRecipW[DayRecipBits-1:0];

  // Cycle split: days / 1461, operand below 2^16.
  localparam int unsigned CycShift    = 27;
  localparam logic [63:0] CycRecipW   = ((64'd1 << CycShift) + 64'd1460) / 64'd1461;
  localparam int unsigned CycRecipBits = 17;
  localparam logic [CycRecipBits-1:0] CycRecip = CycRecipW[CycRecipBits-1:0];

  // Hour split: sod / 3600 = (sod >> 4) / 225, operand below 2^13.
  localparam int unsigned HourPreShift = 4;
  localparam int unsigned HourShift    = 21;
  localparam logic [63:0] HourRecipW   = ((64'd1 << HourShift) + 64'd224) / 64'd225;
  localparam int unsigned HourRecipBits = 14;
  localparam logic [HourRecipBits-1:0] HourRecip = HourRecipW[HourRecipBits-1:0];

  // Minute split: soh / 60, operand below 2^12.
  localparam int unsigned MinShift    = 18;
  localparam logic [63:0] MinRecipW   = ((64'd1 << MinShift) + 64'd59) / 64'd60;
  localparam int unsigned MinRecipBits = 13;
  localparam logic [MinRecipBits-1:0] MinRecip = MinRecipW[MinRecipBits-1:0];

  // Year split inside a cycle: (doy - 1) / 365, operand below 2^11.
  localparam int unsigned YrShift     = 20;
  localparam logic [63:0] YrRecipW    = ((64'd1 << YrShift) + 64'd364) / 64'd365;
  localparam int unsigned YrRecipBits = 12;
  localparam logic [YrRecipBits-1:0] YrRecip = YrRecipW[YrRecipBits-1:0];

  // First day of each month in a leap year, counted from 0
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd60;
      4'd3:    s = 9'd91;
      4'd4:    s = 9'd121;
      4'd5:    s = 9'd152;
      4'd6:    s = 9'd182;
      4'd7:    s = 9'd213;
      4'd8:    s = 9'd244;
      4'd9:    s = 9'd274;
      4'd10:   s = 9'd305;
      4'd11:   s = 9'd335;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/epoch_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 00:00:00 into second, minute, hour,
// day of month, month and year through a seven-stage reciprocal pipeline.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Payload
//  in_      in   in_valid/in_ready   in_epoch_seconds[30:0]
//  out_     out  out_valid/out_ready out_second, out_minute, out_hour,
//                                    out_day_of_month, out_month_index, out_year
//
//  One beat per cycle in and out while no stall holds the pipe; out_valid is the last rank's valid flag.
//  Seven register ranks, the first loaded at the accept edge, with one or two
//  constant reciprocal multiplies or short add/compare steps between ranks.
//  Reset (rst_n low, synchronous) clears all stage valid flags.
//  A stall on out_ready freezes every stage; in_ready drops with it.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_index,
  output logic [10:0] out_year
);

  // Pipeline advance: whole pipe moves unless the output beat is stuck
  logic adv;
  logic [ep2cal_pkg::NumStages-1:0] vld_r, vld_nxt;

  assign adv       = !vld_r[ep2cal_pkg::NumStages-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[ep2cal_pkg::NumStages-1];

  // Stage registers
  logic [ep2cal_pkg::EpochW-1:0]    s1_t_r, s2_t_r;
  logic [ep2cal_pkg::DaysW-1:0]     s2_days_r;
  logic [ep2cal_pkg::SodW-1:0]      s3_sod_r, s4_sod_r;
  logic [ep2cal_pkg::Days1900W-1:0] s3_dd_r;
  logic [ep2cal_pkg::CycW-1:0]      s3_cyc_r;
  logic [ep2cal_pkg::HourW-1:0]     s4_hour_r, s5_hour_r, s6_hour_r;
  logic [ep2cal_pkg::DoyCycW-1:0]   s4_doy_r, s5_x_r;
  logic [ep2cal_pkg::YearW-1:0]     s4_year_r, s5_year_r, s6_year_r;
  logic [ep2cal_pkg::SohW-1:0]      s5_soh_r, s6_soh_r;
  logic [ep2cal_pkg::YqW-1:0]       s5_yq_r;
  logic [ep2cal_pkg::MinW-1:0]      s6_min_r;
  logic [ep2cal_pkg::DoyW-1:0]      s6_doy_r;

  // Next values
  logic [ep2cal_pkg::DaysW-1:0]     s2_days_nxt;
  logic [ep2cal_pkg::SodW-1:0]      s3_sod_nxt;
  logic [ep2cal_pkg::Days1900W-1:0] s3_dd_nxt;
  logic [ep2cal_pkg::CycW-1:0]      s3_cyc_nxt;
  logic [ep2cal_pkg::HourW-1:0]     s4_hour_nxt;
  logic [ep2cal_pkg::DoyCycW-1:0]   s4_doy_nxt, s5_x_nxt;
  logic [ep2cal_pkg::YearW-1:0]     s4_year_nxt, s6_year_nxt;
  logic [ep2cal_pkg::SohW-1:0]      s5_soh_nxt;
  logic [ep2cal_pkg::YqW-1:0]       s5_yq_nxt;
  logic [ep2cal_pkg::MinW-1:0]      s6_min_nxt;
  logic [ep2cal_pkg::DoyW-1:0]      s6_doy_nxt;
  logic [ep2cal_pkg::SecW-1:0]      sec_nxt;
  logic [ep2cal_pkg::DayW-1:0]      day_nxt;
  logic [ep2cal_pkg::MonthW-1:0]    month_nxt;

  // Stage 1 -> 2: whole days since 1970
  logic [48:0] days_prod;
  always_comb begin
    days_prod   = 49'(s1_t_r[ep2cal_pkg::EpochW-1:ep2cal_pkg::DayPreShift]) *
                  49'(ep2cal_pkg::DayRecip);
    s2_days_nxt = days_prod[ep2cal_pkg::DayShift +: ep2cal_pkg::DaysW];
  end

  // Stage 2 -> 3: second of day, days since 1900, four-year cycle count
  logic [ep2cal_pkg::EpochW-1:0] day_secs;
  logic [32:0] cyc_prod;
  always_comb begin
    day_secs   = ep2cal_pkg::EpochW'(s2_days_r) *
                 ep2cal_pkg::EpochW'(ep2cal_pkg::SecsPerDay);
    s3_sod_nxt = ep2cal_pkg::SodW'(s2_t_r - day_secs);
    s3_dd_nxt  = ep2cal_pkg::Days1900W'(s2_days_r) +
                 ep2cal_pkg::Days1900W'(ep2cal_pkg::Days1900To1970);
    cyc_prod   = 33'(s3_dd_nxt) * 33'(ep2cal_pkg::CycRecip);
    s3_cyc_nxt = cyc_prod[ep2cal_pkg::CycShift +: ep2cal_pkg::CycW];
  end

  // Stage 3 -> 4: hour, day within cycle, cycle base year
  logic [26:0] hour_prod;
  always_comb begin
    hour_prod   = 27'(s3_sod_r[ep2cal_pkg::SodW-1:ep2cal_pkg::HourPreShift]) *
                  27'(ep2cal_pkg::HourRecip);
    s4_hour_nxt = hour_prod[ep2cal_pkg::HourShift +: ep2cal_pkg::HourW];
    s4_doy_nxt  = ep2cal_pkg::DoyCycW'(s3_dd_r - ep2cal_pkg::Days1900W'(s3_cyc_r) *
                  ep2cal_pkg::Days1900W'(ep2cal_pkg::DaysPerCycle));
    s4_year_nxt = ep2cal_pkg::YearW'(ep2cal_pkg::BaseYear) +
                  ep2cal_pkg::YearW'({s3_cyc_r, 2'b00});
  end

  // Stage 4 -> 5: second of hour; years past the leading leap year
  logic        past_leap;
  logic [ep2cal_pkg::DoyCycW-1:0] doy_m1;
  logic [21:0] yq_prod;
  always_comb begin
    s5_soh_nxt = ep2cal_pkg::SohW'(s4_sod_r - ep2cal_pkg::SodW'(s4_hour_r) *
                 ep2cal_pkg::SodW'(ep2cal_pkg::SecsPerHour));
    past_leap  = s4_doy_r >= ep2cal_pkg::DoyCycW'(ep2cal_pkg::LeapYearDays);
    doy_m1     = s4_doy_r - ep2cal_pkg::DoyCycW'(1);
    yq_prod    = 22'(doy_m1) * 22'(ep2cal_pkg::YrRecip);
    if (past_leap) begin
      s5_x_nxt  = doy_m1;
      s5_yq_nxt = yq_prod[ep2cal_pkg::YrShift +: ep2cal_pkg::YqW];
    end else begin
      s5_x_nxt  = s4_doy_r;
      s5_yq_nxt = '0;
    end
  end

  // Stage 5 -> 6: minute, day of year, full year
  logic [23:0] min_prod;
  always_comb begin
    min_prod    = 24'(s5_soh_r) * 24'(ep2cal_pkg::MinRecip);
    s6_min_nxt  = min_prod[ep2cal_pkg::MinShift +: ep2cal_pkg::MinW];
    s6_doy_nxt  = ep2cal_pkg::DoyW'(s5_x_r - ep2cal_pkg::DoyCycW'(s5_yq_r) *
                  ep2cal_pkg::DoyCycW'(ep2cal_pkg::DaysPerYear));
    s6_year_nxt = s5_year_r + ep2cal_pkg::YearW'(s5_yq_r);
  end

  // Stage 6 -> 7: second, skip Feb 29 in common years, month search
  logic                       skip_feb;
  logic [ep2cal_pkg::DoyW-1:0] doy_adj;
  always_comb begin
    sec_nxt  = ep2cal_pkg::SecW'(s6_soh_r - ep2cal_pkg::SohW'(s6_min_r) *
               ep2cal_pkg::SohW'(ep2cal_pkg::SecsPerMin));
    skip_feb = (s6_year_r[1:0] != 2'b00) &&
               (s6_doy_r >= ep2cal_pkg::DoyW'(ep2cal_pkg::FebEndCommon));
    doy_adj  = s6_doy_r + ep2cal_pkg::DoyW'(skip_feb);
    month_nxt = '0;
    for (int m = 1; m < ep2cal_pkg::NumMonths; m++) begin
      if (doy_adj >= ep2cal_pkg::month_start(ep2cal_pkg::MonthW'(m))) begin
        month_nxt = ep2cal_pkg::MonthW'(m);
      end
    end
    day_nxt = ep2cal_pkg::DayW'(doy_adj - ep2cal_pkg::month_start(month_nxt) +
              ep2cal_pkg::DoyW'(1));
  end

  // Valid flags shift with the pipe
  assign vld_nxt = {vld_r[ep2cal_pkg::NumStages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t_r           <= in_epoch_seconds;
      s2_t_r           <= s1_t_r;
      s2_days_r        <= s2_days_nxt;
      s3_sod_r         <= s3_sod_nxt;
      s3_dd_r          <= s3_dd_nxt;
      s3_cyc_r         <= s3_cyc_nxt;
      s4_sod_r         <= s3_sod_r;
      s4_hour_r        <= s4_hour_nxt;
      s4_doy_r         <= s4_doy_nxt;
      s4_year_r        <= s4_year_nxt;
      s5_soh_r         <= s5_soh_nxt;
      s5_hour_r        <= s4_hour_r;
      s5_x_r           <= s5_x_nxt;
      s5_yq_r          <= s5_yq_nxt;
      s5_year_r        <= s4_year_r;
      s6_soh_r         <= s5_soh_r;
      s6_min_r         <= s6_min_nxt;
      s6_hour_r        <= s5_hour_r;
      s6_doy_r         <= s6_doy_nxt;
      s6_year_r        <= s6_year_nxt;
      out_second       <= sec_nxt;
      out_minute       <= s6_min_r;
      out_hour         <= s6_hour_r;
      out_day_of_month <= day_nxt;
      out_month_index  <= month_nxt;
      out_year         <= s6_year_r;
    end
  end

endmodule

// ===== sv/ep2cal_chk.sv =====
// ----------------------------------------------------------------------------
// ep2cal_chk
// Port-level checks for the calendar converter, bound to the top level.
// ----------------------------------------------------------------------------
module ep2cal_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_second,
  input logic [5:0]  out_minute,
  input logic [4:0]  out_hour,
  input logic [4:0]  out_day_of_month,
  input logic [3:0]  out_month_index,
  input logic [10:0] out_year
);

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Input side only blocks while the output beat is stuck
  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low without output backpressure");

  // Time of day fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second < 6'd60) && (out_minute < 6'd60) && (out_hour < 5'd24))
    else $error("time of day out of range");

  // Date fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day_of_month != 5'd0) && (out_month_index < 4'd12) &&
                  (out_year >= 11'd1970) && (out_year <= 11'd2038))
    else $error("calendar date out of range");

endmodule

bind epoch_seconds_to_calendar_top ep2cal_chk u_ep2cal_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_second       (out_second),
  .out_minute       (out_minute),
  .out_hour         (out_hour),
  .out_day_of_month (out_day_of_month),
  .out_month_index  (out_month_index),
  .out_year         (out_year)
);
